FILE: sv/telemetry_line_parser_defines.svh
// Assertion macros for the telemetry line parser.
`ifndef TELEMETRY_LINE_PARSER_DEFINES_SVH
`define TELEMETRY_LINE_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define TLP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tlp assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define TLP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tlp assertion failed");

`endif

FILE: sv/tlp_pkg.sv
package tlp_pkg;

	localparam int BYTE_W = 8;
	localparam int ACC_W  = 13;
	localparam int HUM_W  = 12;
	localparam int BAT_W  = 14;

	localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
	localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CH_ONE   = 8'h31;
	localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
	localparam logic [BYTE_W-1:0] CH_A     = 8'h41;
	localparam logic [BYTE_W-1:0] CH_N     = 8'h4E;

	localparam logic [ACC_W-1:0] ACC_SAT = 13'd8191;
	localparam logic [ACC_W-1:0] HUM_MAX = 13'd4095;
	localparam logic [ACC_W-1:0] BAT_MAX = 13'd5000;

	typedef logic [BYTE_W-1:0]       byte_t;
	typedef logic [ACC_W-1:0]        acc_t;
	typedef logic [HUM_W-1:0]        hum_t;
	typedef logic signed [BAT_W-1:0] bat_t;

endpackage

FILE: sv/tlp_intf.sv
interface tlp_byte_if;
	logic             valid;
	logic             ready;
	tlp_pkg::byte_t   data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

interface tlp_result_if;
	logic             valid;
	logic             ready;
	tlp_pkg::hum_t    humidity;
	tlp_pkg::bat_t    battery_millivolts;
	logic             versioned_line;

	modport source (output valid, output humidity, output battery_millivolts,
		output versioned_line, input ready);
	modport sink   (input valid, input humidity, input battery_millivolts,
		input versioned_line, output ready);
endinterface

FILE: sv/telemetry_line_parser.sv
// The result of a good line is valid in the cycle after its LF beat is accepted.
// Throughput: one byte per cycle; the parser state is updated in the accepting cycle.
// A pending result that is not taken holds off stream.ready; taking it frees the slot
// in the same cycle, so a byte can follow every cycle while results keep moving.
// Reset (arst_n low) returns the parser to the start of a line and empties the result.
`include "telemetry_line_parser_defines.svh"

module telemetry_line_parser #(
	parameter int LINE_BYTES = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	tlp_byte_if.sink             stream,
	tlp_result_if.source         result
);

	localparam int CNT_W = $clog2(LINE_BYTES);
	localparam logic [CNT_W-1:0] CNT_LIM = CNT_W'(LINE_BYTES - 1);

	typedef enum logic [3:0] {
		PH_START,
		PH_PFX_N,
		PH_PFX_ONE,
		PH_PFX_COMMA,
		PH_HUM_FIRST,
		PH_HUM,
		PH_BAT_FIRST,
		PH_MINUS,
		PH_MINUS_ONE,
		PH_BAT,
		PH_CR
	} phase_t;

	phase_t             phase_q, phase_n;
	logic [CNT_W-1:0]   cnt_q, cnt_n;
	logic               drop_q, drop_n;
	tlp_pkg::acc_t      acc_q, acc_n;
	logic               neg_q, neg_n;
	tlp_pkg::hum_t      hold_q, hold_n;
	logic               err_q, err_n;
	logic               pfx_q, pfx_n;
	logic               res_valid_q;
	tlp_pkg::hum_t      hum_q;
	tlp_pkg::bat_t      bat_q;
	logic               ver_q;

	logic               acc_in;
	tlp_pkg::byte_t     c;
	logic               is_dig;
	tlp_pkg::acc_t      pushed;
	logic               fin_ok;
	logic               line_ok;
	tlp_pkg::hum_t      hum_out;
	tlp_pkg::bat_t      bat_out;

	function automatic tlp_pkg::acc_t acc_push(tlp_pkg::acc_t a, tlp_pkg::byte_t ch);
		logic [16:0] v;
		v = 17'({a, 3'b000}) + 17'({a, 1'b0}) + 17'(ch[3:0]);
		return (v > 17'(tlp_pkg::ACC_SAT)) ? tlp_pkg::ACC_SAT : v[12:0];
	endfunction

	assign stream.ready = !res_valid_q || result.ready;
	assign acc_in       = stream.valid && stream.ready;
	assign c            = stream.data_byte;
	assign is_dig       = (c >= tlp_pkg::CH_ZERO) && (c <= tlp_pkg::CH_NINE);
	assign pushed       = acc_push(acc_q, c);

	always_comb begin
		unique case (phase_q)
			PH_HUM:       fin_ok = !pfx_q && (acc_q <= tlp_pkg::HUM_MAX);
			PH_MINUS_ONE: fin_ok = 1'b1;
			PH_BAT:       fin_ok = acc_q <= tlp_pkg::BAT_MAX;
			PH_CR:        fin_ok = 1'b1;
			default:      fin_ok = 1'b0;
		endcase
	end

	assign line_ok = fin_ok && !drop_q && (cnt_q != '0) && !err_q;
	assign hum_out = (phase_q == PH_HUM) ? acc_q[11:0] : hold_q;
	assign bat_out = (pfx_q && !neg_q) ? tlp_pkg::bat_t'({1'b0, acc_q}) : '1;

	always_comb begin
		phase_n = phase_q;
		cnt_n   = cnt_q;
		drop_n  = drop_q;
		acc_n   = acc_q;
		neg_n   = neg_q;
		hold_n  = hold_q;
		err_n   = err_q;
		pfx_n   = pfx_q;
		if (acc_in) begin
			if (c == tlp_pkg::CH_LF) begin
				phase_n = PH_START;
				cnt_n   = '0;
				drop_n  = 1'b0;
				acc_n   = '0;
				neg_n   = 1'b0;
				hold_n  = '0;
				err_n   = 1'b0;
				pfx_n   = 1'b0;
			end else if (!drop_q) begin
				if (c == tlp_pkg::CH_NUL || cnt_q >= CNT_LIM) begin
					drop_n = 1'b1;
				end else begin
					cnt_n = cnt_q + 1'b1;
					if (!err_q) begin
						unique case (phase_q)
							PH_START: begin
								if (c == tlp_pkg::CH_A) begin
									phase_n = PH_PFX_N;
								end else if (is_dig) begin
									acc_n   = acc_push('0, c);
									phase_n = PH_HUM;
								end else begin
									err_n = 1'b1;
								end
							end
							PH_PFX_N: begin
								if (c == tlp_pkg::CH_N) phase_n = PH_PFX_ONE;
								else err_n = 1'b1;
							end
							PH_PFX_ONE: begin
								if (c == tlp_pkg::CH_ONE) phase_n = PH_PFX_COMMA;
								else err_n = 1'b1;
							end
							PH_PFX_COMMA: begin
								if (c == tlp_pkg::CH_COMMA) begin
									pfx_n   = 1'b1;
									phase_n = PH_HUM_FIRST;
								end else begin
									err_n = 1'b1;
								end
							end
							PH_HUM_FIRST: begin
								if (is_dig) begin
									acc_n   = acc_push('0, c);
									phase_n = PH_HUM;
								end else begin
									err_n = 1'b1;
								end
							end
							PH_HUM: begin
								if (is_dig) begin
									acc_n = pushed;
								end else if (c == tlp_pkg::CH_COMMA && pfx_q) begin
									if (acc_q > tlp_pkg::HUM_MAX) err_n = 1'b1;
									else hold_n = acc_q[11:0];
									acc_n   = '0;
									phase_n = PH_BAT_FIRST;
								end else if (c == tlp_pkg::CH_CR && !pfx_q) begin
									if (acc_q > tlp_pkg::HUM_MAX) err_n = 1'b1;
									else hold_n = acc_q[11:0];
									phase_n = PH_CR;
								end else begin
									err_n = 1'b1;
								end
							end
							PH_BAT_FIRST: begin
								if (is_dig) begin
									acc_n   = acc_push('0, c);
									phase_n = PH_BAT;
								end else if (c == tlp_pkg::CH_MINUS) begin
									phase_n = PH_MINUS;
								end else begin
									err_n = 1'b1;
								end
							end
							PH_MINUS: begin
								if (c == tlp_pkg::CH_ONE) begin
									neg_n   = 1'b1;
									acc_n   = tlp_pkg::acc_t'(1);
									phase_n = PH_MINUS_ONE;
								end else begin
									err_n = 1'b1;
								end
							end
							PH_MINUS_ONE, PH_BAT: begin
								if (is_dig && phase_q == PH_BAT) begin
									acc_n = pushed;
								end else if (c == tlp_pkg::CH_CR) begin
									if (!neg_q && acc_q > tlp_pkg::BAT_MAX) err_n = 1'b1;
									phase_n = PH_CR;
								end else begin
									err_n = 1'b1;
								end
							end
							default: err_n = 1'b1;
						endcase
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			cnt_q       <= '0;
			drop_q      <= 1'b0;
			acc_q       <= '0;
			neg_q       <= 1'b0;
			hold_q      <= '0;
			err_q       <= 1'b0;
			pfx_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
			drop_q  <= drop_n;
			acc_q   <= acc_n;
			neg_q   <= neg_n;
			hold_q  <= hold_n;
			err_q   <= err_n;
			pfx_q   <= pfx_n;
			if (acc_in) begin
				res_valid_q <= (c == tlp_pkg::CH_LF) && line_ok;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// result payload, loaded on the LF beat of a good line
	always_ff @(posedge clk) begin
		if (acc_in && c == tlp_pkg::CH_LF && line_ok) begin
			hum_q <= hum_out;
			bat_q <= bat_out;
			ver_q <= pfx_q;
		end
	end

	assign result.valid              = res_valid_q;
	assign result.humidity           = hum_q;
	assign result.battery_millivolts = bat_q;
	assign result.versioned_line     = ver_q;

	`TLP_ASSERT_NEXT(a_no_result_off_lf, acc_in && c != tlp_pkg::CH_LF, !res_valid_q)
	`TLP_ASSERT_NEXT(a_lf_clears_line, acc_in && c == tlp_pkg::CH_LF, cnt_q == '0 && !drop_q && !err_q && phase_q == PH_START)
	`TLP_ASSERT_NOW(a_count_bound, 1'b1, cnt_q <= CNT_LIM)
	`TLP_ASSERT_NOW(a_bat_range, res_valid_q, bat_q == -14'sd1 || (bat_q >= 14'sd0 && bat_q <= 14'sd5000))

endmodule
